### rtl/core/alr_pkg.sv
// Shared types and codes for the antialiased line rasterizer.
// No dependencies; used by the top level and the serial divider.
`timescale 1ns / 1ps

package alr_pkg;

   // Request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Number of intensity bits taken from the top of the fraction
   localparam int INTENSITY_BITS = 8;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_PIX0 = 4'b0100,
      ST_PIX1 = 4'b1000
   } state_type;

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/core/alr_divider.sv
// Serial restoring divider: one quotient bit per cycle, FRAC_BITS quotient bits.
// Depends on alr_pkg for the status struct.
`timescale 1ns / 1ps

module alr_divider #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [COORD_BITS-1:0]       dividend,
   input  logic [COORD_BITS-1:0]       divisor,
   output alr_pkg::div_status_type     status,
   output logic [FRAC_BITS-1:0]        quotient
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-1:0] div_ff, div_in;
   logic [FRAC_BITS-1:0]  quo_ff, quo_in;

   logic [COORD_BITS:0]   shifted;
   logic [COORD_BITS:0]   diff;
   logic                  fits;

   // Remainder stays below the divisor, so the doubled value fits one extra bit
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRAC_BITS);
         rem_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

### rtl/core/antialiased_line_rasterizer.sv
// Antialiased line rasterizer, Wu style, fixed point gradient.
// Load request: latched at once; when a divide is needed the block is busy in
// ST_DIV on the serial divider (one quotient bit a cycle), else it stays idle.
// Tick request on an active line: ST_PIX0 then ST_PIX1, two pixels through the
// output register; a tick on an idle block emits none. Synchronous active-high
// reset clears the line state to idle and empties the output register.
`timescale 1ns / 1ps

module antialiased_line_rasterizer #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic                         req_steep,
   input  logic [23:0]                  req_line_color,
   // pixel channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS:0]   rsp_pixel_x,
   output logic signed [COORD_BITS:0]   rsp_pixel_y,
   output logic [23:0]                  rsp_pixel_color,
   output logic [7:0]                   rsp_intensity,
   output logic                         rsp_last
);

   localparam int ACC_W   = COORD_BITS + 1 + FRAC_BITS;
   localparam int SLOPE_W = FRAC_BITS + 2;
   localparam int IB      = alr_pkg::INTENSITY_BITS;
   localparam logic signed [SLOPE_W-1:0] SLOPE_ONE = {2'b01, {FRAC_BITS{1'b0}}};

   // ---------------------------------------------------------------------
   // Line state
   // ---------------------------------------------------------------------
   alr_pkg::state_type               state_ff, state_in;
   logic signed [COORD_BITS-1:0]     major_ff, major_in;
   logic signed [COORD_BITS-1:0]     limit_ff, limit_in;
   logic signed [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [SLOPE_W-1:0]        slope_ff, slope_in;
   logic                             steep_ff, steep_in;
   logic [23:0]                      color_ff, color_in;
   logic                             active_ff, active_in;
   logic                             neg_ff, neg_in;

   // Output register
   logic                             out_valid_ff, out_valid_in;
   logic signed [COORD_BITS:0]       out_x_ff, out_x_in;
   logic signed [COORD_BITS:0]       out_y_ff, out_y_in;
   logic [23:0]                      out_color_ff, out_color_in;
   logic [7:0]                       out_int_ff, out_int_in;
   logic                             out_last_ff, out_last_in;

   // ---------------------------------------------------------------------
   // Load-time geometry: pick major and minor axes, spans and magnitudes
   // ---------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] s_maj, e_maj, s_min, e_min;
   logic signed [COORD_BITS:0]   d_maj, d_min;
   logic [COORD_BITS:0]          abs_maj_w, abs_min_w;
   logic [COORD_BITS-1:0]        abs_maj, abs_min;
   logic                         span_zero;
   logic                         saturate;
   logic                         span_neg;

   assign s_maj = req_steep ? req_start_y : req_start_x;
   assign e_maj = req_steep ? req_end_y   : req_end_x;
   assign s_min = req_steep ? req_start_x : req_start_y;
   assign e_min = req_steep ? req_end_x   : req_end_y;

   assign d_maj = {e_maj[COORD_BITS-1], e_maj} - {s_maj[COORD_BITS-1], s_maj};
   assign d_min = {e_min[COORD_BITS-1], e_min} - {s_min[COORD_BITS-1], s_min};

   // |span| of two C-bit coordinates never exceeds 2^C - 1
   assign abs_maj_w = d_maj[COORD_BITS] ? -d_maj : d_maj;
   assign abs_min_w = d_min[COORD_BITS] ? -d_min : d_min;
   assign abs_maj   = abs_maj_w[COORD_BITS-1:0];
   assign abs_min   = abs_min_w[COORD_BITS-1:0];

   assign span_zero = (d_maj == '0);
   // Minor span at least the major span: quotient reaches or passes one
   assign saturate  = (abs_min >= abs_maj);
   assign span_neg  = d_min[COORD_BITS] ^ d_maj[COORD_BITS];

   // ---------------------------------------------------------------------
   // Serial divider
   // ---------------------------------------------------------------------
   alr_pkg::div_status_type  div_status;
   logic [FRAC_BITS-1:0]     div_quotient;
   logic                     div_start;
   logic signed [SLOPE_W-1:0] div_slope_pos;

   alr_divider #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (abs_min),
      .divisor  (abs_maj),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign div_slope_pos = {2'b00, div_quotient};

   // ---------------------------------------------------------------------
   // Pixel formation from the accumulator
   // ---------------------------------------------------------------------
   logic signed [COORD_BITS:0] whole;
   logic signed [COORD_BITS:0] whole_next;
   logic signed [COORD_BITS:0] major_ext;
   logic [IB-1:0]              frac8;
   logic signed [COORD_BITS:0] major_step;
   logic                       final_step;
   logic                       out_load;

   // Floor of the fixed-point value is an arithmetic shift; wrap matches masking
   assign whole      = acc_ff[ACC_W-1 -: COORD_BITS+1];
   assign whole_next = whole + (COORD_BITS+1)'(1);
   assign frac8      = acc_ff[FRAC_BITS-1 -: IB];
   assign major_ext  = {major_ff[COORD_BITS-1], major_ff};
   assign major_step = major_ext + (COORD_BITS+1)'(1);
   // Signed compare: the limit may sit on either side of zero
   assign final_step = major_step >= $signed({limit_ff[COORD_BITS-1], limit_ff});

   // Output register takes a new pixel when empty or being drained
   assign out_load = !out_valid_ff || rsp_ready;

   logic req_fire;
   assign req_ready = (state_ff == alr_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      major_in     = major_ff;
      limit_in     = limit_ff;
      acc_in       = acc_ff;
      slope_in     = slope_ff;
      steep_in     = steep_ff;
      color_in     = color_ff;
      active_in    = active_ff;
      neg_in       = neg_ff;
      div_start    = 1'b0;

      out_valid_in = out_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_int_in   = out_int_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         alr_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == alr_pkg::OP_LOAD) begin
                  // Latch the new line at once; slope is set here or follows from the divide
                  steep_in  = req_steep;
                  color_in  = req_line_color;
                  major_in  = s_maj;
                  limit_in  = e_maj;
                  acc_in    = {s_min[COORD_BITS-1], s_min, {FRAC_BITS{1'b0}}};
                  active_in = (s_maj < e_maj);
                  neg_in    = span_neg;
                  if (span_zero) begin
                     slope_in = SLOPE_ONE;
                  end else if (saturate) begin
                     slope_in = span_neg ? -SLOPE_ONE : SLOPE_ONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = alr_pkg::ST_DIV;
                  end
               end else if (active_ff) begin
                  state_in = alr_pkg::ST_PIX0;
               end
            end
         end
         alr_pkg::ST_DIV: begin
            // Hold until the quotient is complete, then apply the sign
            if (div_status.done) begin
               slope_in = neg_ff ? -div_slope_pos : div_slope_pos;
               state_in = alr_pkg::ST_IDLE;
            end
         end
         alr_pkg::ST_PIX0: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_x_in     = steep_ff ? whole : major_ext;
               out_y_in     = steep_ff ? major_ext : whole;
               out_color_in = color_ff;
               out_int_in   = ~frac8;
               out_last_in  = 1'b0;
               state_in     = alr_pkg::ST_PIX1;
            end
         end
         alr_pkg::ST_PIX1: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_x_in     = steep_ff ? whole_next : major_ext;
               out_y_in     = steep_ff ? major_ext : whole_next;
               out_color_in = color_ff;
               out_int_in   = frac8;
               out_last_in  = final_step;
               // Advance one major position and one gradient step
               major_in     = major_step[COORD_BITS-1:0];
               acc_in       = acc_ff + {{(COORD_BITS-1){slope_ff[SLOPE_W-1]}}, slope_ff};
               if (final_step) begin
                  active_in = 1'b0;
               end
               state_in     = alr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alr_pkg::ST_IDLE;
         major_ff     <= '0;
         limit_ff     <= '0;
         acc_ff       <= '0;
         slope_ff     <= '0;
         steep_ff     <= 1'b0;
         color_ff     <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         major_ff     <= major_in;
         limit_ff     <= limit_in;
         acc_ff       <= acc_in;
         slope_ff     <= slope_in;
         steep_ff     <= steep_in;
         color_ff     <= color_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      neg_ff       <= neg_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_int_ff   <= out_int_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_intensity   = out_int_ff;
   assign rsp_last        = out_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The divider runs only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == alr_pkg::ST_DIV))
      else $error("divider busy outside the divide state");

   // A tick on an idle line produces no pixels
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_operation == alr_pkg::OP_TICK && !active_ff)
         |=> (state_ff == alr_pkg::ST_IDLE))
      else $error("tick on idle line started pixel output");

   // The first pixel of a pair is always followed by the second
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == alr_pkg::ST_PIX0 && out_load)
         |=> (state_ff == alr_pkg::ST_PIX1 && rsp_valid))
      else $error("second pixel of a pair not scheduled");

   // A pixel pair leaves complementary intensities
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == alr_pkg::ST_PIX1 && out_load)
         |=> (rsp_intensity == ~$past(out_int_ff)))
      else $error("pixel pair intensities do not sum to full scale");

endmodule
